>>> rtl/qvr_pkg.sv
// shared widths for the quaternion vector rotation pipeline
// no dependencies; imported by every rtl module of the block
package qvr_pkg;

  // data word and fixed-point layout
  localparam int WORD_WIDTH = 32;
  localparam int QUAT_FRAC  = 29;

  // sum of squares over four, its root and the normalizing division
  localparam int SQ_W   = 2 * WORD_WIDTH - 1;
  localparam int ROOT_W = WORD_WIDTH;
  localparam int NUM_W  = WORD_WIDTH + QUAT_FRAC;
  localparam int DEN_W  = ROOT_W + 1;
  localparam int QUO_W  = WORD_WIDTH - 1;

  // intermediate product q * (0,v) after rounding to 2^-29 units
  localparam int ACC1_W = 2 * WORD_WIDTH + 2;
  localparam int T_W    = ACC1_W - 15;

  // split of t for the second product
  localparam int TL_W = 26;
  localparam int TH_W = T_W - TL_W;
  localparam int PL_W = TL_W + 1 + WORD_WIDTH;
  localparam int PH_W = TH_W + WORD_WIDTH;
  localparam int PR_W = PH_W + TL_W;
  localparam int ACC2_W = PR_W + 3;
  localparam int R_W    = ACC2_W - 43;

endpackage

>>> rtl/qvr_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on qvr_pkg; carries a sideband word alongside the operand
module qvr_isqrt import qvr_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NS = (SQ_W + 1) / 2;
  localparam int RW = SQ_W + 1;

  logic [SQ_W-1:0]   x_r    [NS];
  logic [RW-1:0]     res_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];
  logic              vld_r  [NS];

  for (genvar j = 0; j < NS; j++) begin : g_st
    localparam logic [RW-1:0] BIT = RW'(1) << (SQ_W - 1 - 2 * j);
    logic [SQ_W-1:0]   xi;
    logic [RW-1:0]     ri;
    logic [SIDE_W-1:0] si;
    logic              vi;
    logic [RW-1:0]     sum;
    logic              ge;

    if (j == 0) begin : g_first
      assign xi = in_x;
      assign ri = '0;
      assign si = in_side;
      assign vi = in_valid;
    end else begin : g_rest
      assign xi = x_r[j-1];
      assign ri = res_r[j-1];
      assign si = side_r[j-1];
      assign vi = vld_r[j-1];
    end

    // trial subtract of res + bit
    assign sum = ri + BIT;
    assign ge  = {1'b0, xi} >= sum;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[j] <= 1'b0;
      end else if (ce) begin
        vld_r[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        x_r[j]    <= ge ? (xi - sum[SQ_W-1:0]) : xi;
        res_r[j]  <= ge ? ((ri >> 1) + BIT) : (ri >> 1);
        side_r[j] <= si;
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_root  = res_r[NS-1][ROOT_W-1:0];
  assign out_side  = side_r[NS-1];

endmodule

>>> rtl/qvr_div.sv
// pipelined restoring divider, four lanes sharing one divisor
// depends on qvr_pkg; one quotient bit per stage, sideband travels along
module qvr_div import qvr_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  logic                 in_valid,
  input  logic [3:0][NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0]     in_den,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [3:0][QUO_W-1:0] out_quo,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int CW = DEN_W + QUO_W;

  logic [3:0][NUM_W-1:0] rem_r  [QUO_W];
  logic [3:0][QUO_W-1:0] quo_r  [QUO_W];
  logic [DEN_W-1:0]      den_r  [QUO_W];
  logic [SIDE_W-1:0]     side_r [QUO_W];
  logic                  vld_r  [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_st
    localparam int B = QUO_W - 1 - i;
    logic [3:0][NUM_W-1:0] ri;
    logic [3:0][QUO_W-1:0] qi;
    logic [DEN_W-1:0]      di;
    logic [SIDE_W-1:0]     si;
    logic                  vi;
    logic [CW-1:0]         dsh;

    if (i == 0) begin : g_first
      assign ri = in_num;
      assign qi = '0;
      assign di = in_den;
      assign si = in_side;
      assign vi = in_valid;
    end else begin : g_rest
      assign ri = rem_r[i-1];
      assign qi = quo_r[i-1];
      assign di = den_r[i-1];
      assign si = side_r[i-1];
      assign vi = vld_r[i-1];
    end

    // shifted divisor for this quotient bit
    assign dsh = CW'(di) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (ce) begin
        vld_r[i] <= vi;
      end
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
      logic ge;
      assign ge = CW'(ri[k]) >= dsh;

      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[i][k] <= ge ? (ri[k] - dsh[NUM_W-1:0]) : ri[k];
          quo_r[i][k] <= {qi[k][QUO_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        den_r[i]  <= di;
        side_r[i] <= si;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

endmodule

>>> rtl/quaternion_vector_rotate.sv
// quaternion vector rotation: v' = vec(q * (0,v) * conj(q) / |q|)
// depends on qvr_pkg, qvr_isqrt and qvr_div
//
// usage:
//   input transfer on s_tvalid/s_tready carries a quaternion (Q2.29) and a
//   vector (Q16.15); output transfer on m_tvalid/m_tready carries the
//   rotated vector (Q16.15, saturated) and two status flags in m_tuser
// throughput: one transfer per cycle in and out, no gaps between items, except while a stall holds the pipeline
// pipeline: from input transfer to m_tvalid, the 32-stage square root of the
//   norm and the 31-stage divider that normalizes the conjugate, plus two
//   stages ahead of the root, one between root and divider and four after
//   the divider
// a non-unit quaternion also scales the vector by its norm; a norm that
//   truncates to zero gives a zero vector with zero_norm set
// reset: rst is synchronous; it clears every valid bit in the pipeline, so
//   no result is produced for items in flight at the time
// stall: while m_tvalid is high and m_tready low the whole pipeline holds,
//   s_tready drops and nothing is lost or repeated; the result stays on
//   m_tdata until taken
module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z (32 bits each)
  input  logic [7*WORD_WIDTH-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // rot_x, rot_y, rot_z (32 bits each)
  output logic [3*WORD_WIDTH-1:0] m_tdata,
  // zero_norm, saturated
  output logic [1:0]             m_tuser
);

  localparam int QS_W   = 4 * WORD_WIDTH;
  localparam int TS_W   = 4 * T_W;
  localparam int SIDE1_W = QS_W + TS_W;
  localparam int SIDE2_W = TS_W + 5;
  localparam int PW     = 2 * WORD_WIDTH;
  localparam logic signed [R_W-1:0] R_MAX = R_W'((64'(1) << (WORD_WIDTH - 1)) - 1);
  localparam logic signed [R_W-1:0] R_MIN = -R_MAX - R_W'(1);

  logic ce;

  // the whole pipeline advances unless a finished result is held
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // input fields
  logic signed [WORD_WIDTH-1:0] q_in [4];
  logic signed [WORD_WIDTH-1:0] v_in [3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      q_in[k] = s_tdata[k*WORD_WIDTH +: WORD_WIDTH];
    end
    for (int k = 0; k < 3; k++) begin
      v_in[k] = s_tdata[(4+k)*WORD_WIDTH +: WORD_WIDTH];
    end
  end

  // stage 1: squares of q and the twelve products of q * (0,v)
  logic                           v1;
  logic [2*WORD_WIDTH-1:0]        sq_r [4];
  logic signed [2*WORD_WIDTH-1:0] pr_r [12];
  logic [3:0][WORD_WIDTH-1:0]     q1_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        sq_r[k] <= PW'(q_in[k]) * PW'(q_in[k]);
        q1_r[k] <= q_in[k];
      end
      pr_r[0]  <= PW'(q_in[1]) * PW'(v_in[0]);
      pr_r[1]  <= PW'(q_in[2]) * PW'(v_in[1]);
      pr_r[2]  <= PW'(q_in[3]) * PW'(v_in[2]);
      pr_r[3]  <= PW'(q_in[0]) * PW'(v_in[0]);
      pr_r[4]  <= PW'(q_in[2]) * PW'(v_in[2]);
      pr_r[5]  <= PW'(q_in[3]) * PW'(v_in[1]);
      pr_r[6]  <= PW'(q_in[0]) * PW'(v_in[1]);
      pr_r[7]  <= PW'(q_in[3]) * PW'(v_in[0]);
      pr_r[8]  <= PW'(q_in[1]) * PW'(v_in[2]);
      pr_r[9]  <= PW'(q_in[0]) * PW'(v_in[2]);
      pr_r[10] <= PW'(q_in[1]) * PW'(v_in[1]);
      pr_r[11] <= PW'(q_in[2]) * PW'(v_in[0]);
    end
  end

  // stage 2: norm squared over four and rounded t components
  logic                       v2;
  logic [SQ_W-1:0]            s4_r;
  logic [3:0][T_W-1:0]        t2_r;
  logic [3:0][WORD_WIDTH-1:0] q2_r;
  logic [SQ_W+2:0]            sq_sum;
  logic signed [ACC1_W-1:0]   pe [12];
  logic signed [ACC1_W-1:0]   a_sum [4];

  always_comb begin
    sq_sum = '0;
    for (int k = 0; k < 4; k++) begin
      sq_sum = sq_sum + (SQ_W+3)'(sq_r[k]);
    end
    for (int k = 0; k < 12; k++) begin
      pe[k] = ACC1_W'(pr_r[k]);
    end
    a_sum[0] = -pe[0] - pe[1] - pe[2] + ACC1_W'(1 << 14);
    a_sum[1] =  pe[3] + pe[4] - pe[5] + ACC1_W'(1 << 14);
    a_sum[2] =  pe[6] + pe[7] - pe[8] + ACC1_W'(1 << 14);
    a_sum[3] =  pe[9] + pe[10] - pe[11] + ACC1_W'(1 << 14);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_r <= sq_sum[SQ_W+1:2];
      q2_r <= q1_r;
      for (int k = 0; k < 4; k++) begin
        t2_r[k] <= a_sum[k][ACC1_W-1:15];
      end
    end
  end

  // norm root
  logic                       vs;
  logic [ROOT_W-1:0]          n_s;
  logic [SIDE1_W-1:0]         side_s;
  logic [3:0][WORD_WIDTH-1:0] q_s;
  logic [3:0][T_W-1:0]        t_s;

  qvr_isqrt #(
    .SIDE_W (SIDE1_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v2),
    .in_x      (s4_r),
    .in_side   ({q2_r, t2_r}),
    .out_valid (vs),
    .out_root  (n_s),
    .out_side  (side_s)
  );

  assign {q_s, t_s} = side_s;

  // prep stage: dividend |c| * 2^29 + n per component and shared divisor 2n
  logic                  vp;
  logic [3:0][NUM_W-1:0] num_r;
  logic [DEN_W-1:0]      den_r;
  logic [SIDE2_W-1:0]    side_p;
  logic [3:0]            sg;
  logic [WORD_WIDTH-1:0] mag [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sg[k]  = q_s[k][WORD_WIDTH-1];
      mag[k] = sg[k] ? (~q_s[k] + WORD_WIDTH'(1)) : q_s[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (ce) begin
      vp <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        num_r[k] <= {mag[k], QUAT_FRAC'(0)} + NUM_W'(n_s);
      end
      den_r  <= {n_s, 1'b0};
      side_p <= {t_s, (n_s == '0), sg};
    end
  end

  // normalizing division
  logic                  vd;
  logic [3:0][QUO_W-1:0] quo_d;
  logic [SIDE2_W-1:0]    side_d;
  logic [3:0][T_W-1:0]   t_d;
  logic                  zero_d;
  logic [3:0]            sg_d;

  qvr_div #(
    .SIDE_W (SIDE2_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (vp),
    .in_num    (num_r),
    .in_den    (den_r),
    .in_side   (side_p),
    .out_valid (vd),
    .out_quo   (quo_d),
    .out_side  (side_d)
  );

  assign {t_d, zero_d, sg_d} = side_d;

  // conjugate signs: scalar keeps the sign of w, vector part flips
  logic                         v4;
  logic signed [WORD_WIDTH-1:0] p_r [4];
  logic [3:0][T_W-1:0]          t4_r;
  logic                         z4_r;
  logic signed [WORD_WIDTH-1:0] pos [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pos[k] = $signed({1'b0, quo_d[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ce) begin
      v4 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p_r[0] <= sg_d[0] ? -pos[0] : pos[0];
      for (int k = 1; k < 4; k++) begin
        p_r[k] <= sg_d[k] ? pos[k] : -pos[k];
      end
      t4_r <= t_d;
      z4_r <= zero_d;
    end
  end

  // stage 5: split products t * p, low and high halves of t
  logic                   v5;
  logic                   z5_r;
  logic signed [PL_W-1:0] pl_r [3][4];
  logic signed [PH_W-1:0] ph_r [3][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (ce) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      z5_r <= z4_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J  = i + 1;
    localparam int KA = (i + 1) % 3 + 1;
    localparam int LA = (i + 2) % 3 + 1;
    for (genvar m = 0; m < 4; m++) begin : g_term
      localparam int TI = (m == 0) ? 0 : (m == 1) ? J : (m == 2) ? KA : LA;
      localparam int PI = (m == 0) ? J : (m == 1) ? 0 : (m == 2) ? LA : KA;
      always_ff @(posedge clk) begin
        if (ce) begin
          pl_r[i][m] <= PL_W'($signed({1'b0, t4_r[TI][TL_W-1:0]})) * PL_W'(p_r[PI]);
          ph_r[i][m] <= PH_W'($signed(t4_r[TI][T_W-1:TL_W])) * PH_W'(p_r[PI]);
        end
      end
    end
  end

  // stage 6: recombine halves into full products
  logic                   v6;
  logic                   z6_r;
  logic signed [PR_W-1:0] prod_r [3][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (ce) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      z6_r <= z5_r;
      for (int i = 0; i < 3; i++) begin
        for (int m = 0; m < 4; m++) begin
          prod_r[i][m] <= (PR_W'(ph_r[i][m]) <<< TL_W) + PR_W'(pl_r[i][m]);
        end
      end
    end
  end

  // stage 7: sum, round to Q16.15, saturate into the output register
  logic signed [ACC2_W-1:0]     acc [3];
  logic signed [R_W-1:0]        rr  [3];
  logic [2:0]                   hi_ovf;
  logic [2:0]                   lo_ovf;
  logic [3*WORD_WIDTH-1:0]      data_next;
  logic                         sat_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC2_W'(prod_r[i][0]) + ACC2_W'(prod_r[i][1])
             + ACC2_W'(prod_r[i][2]) - ACC2_W'(prod_r[i][3])
             + (ACC2_W'(1) <<< 42);
      rr[i]     = acc[i][ACC2_W-1:43];
      hi_ovf[i] = rr[i] > R_MAX;
      lo_ovf[i] = rr[i] < R_MIN;
      if (z6_r) begin
        data_next[i*WORD_WIDTH +: WORD_WIDTH] = '0;
      end else if (hi_ovf[i]) begin
        data_next[i*WORD_WIDTH +: WORD_WIDTH] = R_MAX[WORD_WIDTH-1:0];
      end else if (lo_ovf[i]) begin
        data_next[i*WORD_WIDTH +: WORD_WIDTH] = R_MIN[WORD_WIDTH-1:0];
      end else begin
        data_next[i*WORD_WIDTH +: WORD_WIDTH] = rr[i][WORD_WIDTH-1:0];
      end
    end
    sat_next = !z6_r && ((|hi_ovf) || (|lo_ovf));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= data_next;
      m_tuser <= {sat_next, z6_r};
    end
  end

endmodule
